>>> sv/bgl_pkg.sv
// Shared types and constants for the button gesture LED mode block.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package bgl_pkg;

   // Width of every configuration register and of the CSR write data.
   localparam int REG_WIDTH       = 24;
   localparam int CSR_INDEX_WIDTH = 3;

   // Register indexes on the CSR port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAP         = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLINK_HALF  = 3'd3;

   // Register values after reset.
   localparam logic [REG_WIDTH-1:0] RST_LONG_PRESS = 24'd500000;
   localparam logic [REG_WIDTH-1:0] RST_GAP        = 24'd1000000;
   localparam logic [REG_WIDTH-1:0] RST_WINDOW     = 24'd1000000;
   localparam logic [REG_WIDTH-1:0] RST_BLINK_HALF = 24'd100000;

   // LED mode codes, as seen on the result channel.
   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_STEADY = 2'd1;
   localparam logic [1:0] MODE_BLINK  = 2'd2;

   // Gesture event codes, as seen on the result channel.
   localparam logic [1:0] GESTURE_NONE   = 2'd0;
   localparam logic [1:0] GESTURE_LONG   = 2'd1;
   localparam logic [1:0] GESTURE_DOUBLE = 2'd2;

   // Gesture phase, one-hot.
   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_LONG   = 4'b0010,
      PH_GAP    = 4'b0100,
      PH_WINDOW = 4'b1000
   } phase_type;

   // Raw configuration registers handed to the gesture engine.
   typedef struct packed {
      logic [REG_WIDTH-1:0] long_press_ticks;
      logic [REG_WIDTH-1:0] gap_ticks;
      logic [REG_WIDTH-1:0] window_ticks;
      logic [REG_WIDTH-1:0] blink_half_period;
   } cfg_regs_type;

   // One result transaction.
   typedef struct packed {
      logic       led;
      logic [1:0] mode;
      logic [1:0] gesture;
   } result_type;

endpackage

>>> sv/bgl_cfg.sv
// Configuration register file for the button gesture LED mode block.
// Depends on bgl_pkg for the register indexes, reset values and struct.
`timescale 1ns / 1ps

module bgl_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bgl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bgl_pkg::REG_WIDTH-1:0]        csr_wdata,
   output bgl_pkg::cfg_regs_type                cfg_regs
);

   bgl_pkg::cfg_regs_type regs_ff;
   bgl_pkg::cfg_regs_type regs_in;

   // Decode the write; an index beyond the register list leaves all unchanged.
   always_comb begin
      regs_in = regs_ff;
      if (csr_we) begin
         case (csr_index)
            bgl_pkg::CSR_LONG_PRESS: regs_in.long_press_ticks  = csr_wdata;
            bgl_pkg::CSR_GAP:        regs_in.gap_ticks         = csr_wdata;
            bgl_pkg::CSR_WINDOW:     regs_in.window_ticks      = csr_wdata;
            bgl_pkg::CSR_BLINK_HALF: regs_in.blink_half_period = csr_wdata;
            default:                 regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.long_press_ticks  <= bgl_pkg::RST_LONG_PRESS;
         regs_ff.gap_ticks         <= bgl_pkg::RST_GAP;
         regs_ff.window_ticks      <= bgl_pkg::RST_WINDOW;
         regs_ff.blink_half_period <= bgl_pkg::RST_BLINK_HALF;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign cfg_regs = regs_ff;

endmodule

>>> sv/bgl_fsm.sv
// Gesture engine: phase machine, phase counter, LED mode and blink timer.
// Depends on bgl_pkg; advances one tick for each enabled cycle.
`timescale 1ns / 1ps

module bgl_fsm #(
   parameter int COUNT_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick_en,
   input  logic                  button,
   input  bgl_pkg::cfg_regs_type cfg_regs,
   output bgl_pkg::result_type   result
);

   localparam int CW = COUNT_BITS;

   bgl_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]      phase_count_ff, phase_count_in;
   logic [1:0]         led_mode_ff, led_mode_in;
   logic               led_level_ff, led_level_in;
   logic [CW-1:0]      blink_count_ff, blink_count_in;
   logic [1:0]         gesture;

   logic [CW-1:0] long_cut, gap_cut, window_cut, blink_cut;
   logic [CW-1:0] long_lim, gap_lim, window_lim, blink_lim;
   logic [CW-1:0] phase_inc, blink_inc;

   // Registers are cut or widened to the counter width; zero acts as one.
   assign long_cut   = CW'(cfg_regs.long_press_ticks);
   assign gap_cut    = CW'(cfg_regs.gap_ticks);
   assign window_cut = CW'(cfg_regs.window_ticks);
   assign blink_cut  = CW'(cfg_regs.blink_half_period);
   assign long_lim   = (long_cut   == '0) ? CW'(1) : long_cut;
   assign gap_lim    = (gap_cut    == '0) ? CW'(1) : gap_cut;
   assign window_lim = (window_cut == '0) ? CW'(1) : window_cut;
   assign blink_lim  = (blink_cut  == '0) ? CW'(1) : blink_cut;

   // Incremented counters wrap at the counter width.
   assign phase_inc = phase_count_ff + CW'(1);
   assign blink_inc = blink_count_ff + CW'(1);

   // Next state for one tick.
   always_comb begin
      phase_in       = phase_ff;
      phase_count_in = phase_count_ff;
      led_mode_in    = led_mode_ff;
      led_level_in   = led_level_ff;
      blink_count_in = blink_count_ff;
      gesture        = bgl_pkg::GESTURE_NONE;
      case (phase_ff)
         bgl_pkg::PH_IDLE: begin
            // A press only starts the check; blinking runs on quiet idle ticks.
            if (button) begin
               phase_in       = bgl_pkg::PH_LONG;
               phase_count_in = '0;
            end else if (led_mode_ff == bgl_pkg::MODE_BLINK) begin
               if (blink_inc >= blink_lim) begin
                  led_level_in   = ~led_level_ff;
                  blink_count_in = '0;
               end else begin
                  blink_count_in = blink_inc;
               end
            end
         end
         bgl_pkg::PH_LONG: begin
            if (!button) begin
               phase_count_in = '0;
               phase_in       = (gap_cut == '0) ? bgl_pkg::PH_WINDOW : bgl_pkg::PH_GAP;
            end else if (phase_inc >= long_lim) begin
               gesture        = bgl_pkg::GESTURE_LONG;
               led_mode_in    = bgl_pkg::MODE_STEADY;
               led_level_in   = 1'b1;
               phase_in       = bgl_pkg::PH_IDLE;
               phase_count_in = '0;
            end else begin
               phase_count_in = phase_inc;
            end
         end
         bgl_pkg::PH_GAP: begin
            if (phase_inc >= gap_lim) begin
               phase_in       = bgl_pkg::PH_WINDOW;
               phase_count_in = '0;
            end else begin
               phase_count_in = phase_inc;
            end
         end
         bgl_pkg::PH_WINDOW: begin
            // A second press inside the window is a double click.
            if (button) begin
               gesture        = bgl_pkg::GESTURE_DOUBLE;
               led_mode_in    = bgl_pkg::MODE_BLINK;
               led_level_in   = ~led_level_ff;
               blink_count_in = '0;
               phase_in       = bgl_pkg::PH_IDLE;
               phase_count_in = '0;
            end else if (phase_inc >= window_lim) begin
               phase_in       = bgl_pkg::PH_IDLE;
               phase_count_in = '0;
            end else begin
               phase_count_in = phase_inc;
            end
         end
         default: begin
            phase_in       = bgl_pkg::PH_IDLE;
            phase_count_in = '0;
         end
      endcase
   end

   // State advances only when a transaction is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= bgl_pkg::PH_IDLE;
         phase_count_ff <= '0;
         led_mode_ff    <= bgl_pkg::MODE_NONE;
         led_level_ff   <= 1'b0;
         blink_count_ff <= '0;
      end else if (tick_en) begin
         phase_ff       <= phase_in;
         phase_count_ff <= phase_count_in;
         led_mode_ff    <= led_mode_in;
         led_level_ff   <= led_level_in;
         blink_count_ff <= blink_count_in;
      end
   end

   // The result carries the state after this tick.
   assign result.led     = led_level_in;
   assign result.mode    = led_mode_in;
   assign result.gesture = gesture;

   // The phase counter is always cleared while idle.
   a_idle_count_zero : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bgl_pkg::PH_IDLE) |-> (phase_count_ff == '0))
      else $error("phase counter not zero in idle");

   // Once a mode is chosen it never returns to none.
   a_mode_sticky : assert property (@(posedge clock) disable iff (reset)
      (led_mode_ff != bgl_pkg::MODE_NONE) |=> (led_mode_ff != bgl_pkg::MODE_NONE))
      else $error("LED mode fell back to none");

   // The phase register always holds exactly one phase.
   a_phase_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register not one-hot");

endmodule

>>> sv/button_gesture_led_mode.sv
// A request transaction passes through the input register and then the result register to the response channel.
// Throughput: one transaction per cycle; while a result waits, the input register can take
// one more transaction, after which requests stall until the result is taken.
// Reset (synchronous, active high) empties both registers, returns the gesture phase to
// idle with the LED off and no mode, and restores the configuration reset values.
// Top level of the button gesture LED mode block; uses bgl_pkg, bgl_cfg and bgl_fsm.
`timescale 1ns / 1ps

module button_gesture_led_mode #(
   parameter int COUNT_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_button,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_led,
   output logic [1:0]                           rsp_mode,
   output logic [1:0]                           rsp_gesture,
   input  logic                                 csr_we,
   input  logic [bgl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bgl_pkg::REG_WIDTH-1:0]        csr_wdata
);

   bgl_pkg::cfg_regs_type cfg_regs;
   bgl_pkg::result_type   step_result;

   logic                in_valid_ff, in_valid_in;
   logic                in_button_ff, in_button_in;
   logic                out_valid_ff, out_valid_in;
   bgl_pkg::result_type out_result_ff, out_result_in;
   logic                out_free;
   logic                advance;

   bgl_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_regs  (cfg_regs)
   );

   bgl_fsm #(
      .COUNT_BITS (COUNT_BITS)
   ) u_fsm (
      .clock    (clock),
      .reset    (reset),
      .tick_en  (advance),
      .button   (in_button_ff),
      .cfg_regs (cfg_regs),
      .result   (step_result)
   );

   // Handshake: the input register moves on when the result register can take it.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_button_in = in_button_ff;
      if (req_valid && req_ready) begin
         in_valid_in  = 1'b1;
         in_button_in = req_button;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      if (advance) begin
         out_valid_in  = 1'b1;
         out_result_in = step_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_button_ff  <= in_button_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_led     = out_result_ff.led;
   assign rsp_mode    = out_result_ff.mode;
   assign rsp_gesture = out_result_ff.gesture;

   // A long press always shows steady mode with the LED lit.
   a_long_steady : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_gesture == bgl_pkg::GESTURE_LONG) |->
         (rsp_mode == bgl_pkg::MODE_STEADY && rsp_led))
      else $error("long press without steady mode");

   // A double click always shows blink mode.
   a_double_blink : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_gesture == bgl_pkg::GESTURE_DOUBLE) |->
         (rsp_mode == bgl_pkg::MODE_BLINK))
      else $error("double click without blink mode");

   // With both registers full and the result stalled, no request is taken.
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request accepted while pipeline full");

endmodule

>>> test/button_gesture_led_mode_tb.sv
// Self-checking testbench for button_gesture_led_mode: directed table, then random gestures.
// Depends on bgl_pkg and the button_gesture_led_mode top level, which uses bgl_cfg and bgl_fsm.
`timescale 1ns / 1ps

module button_gesture_led_mode_tb;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 170;
   localparam int EXTREME_ITEMS = 40;
   localparam int SPAN_CAP = 40;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [bgl_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 3'd7;
   localparam logic [bgl_pkg::REG_WIDTH-1:0] REG_MAX = {bgl_pkg::REG_WIDTH{1'b1}};

   typedef enum logic {ROW_BUTTON, ROW_CSR} row_kind_type;

   // One line of the directed table: a button sample or a register write.
   typedef struct {
      row_kind_type                        kind;
      logic [bgl_pkg::CSR_INDEX_WIDTH-1:0] index;
      logic [bgl_pkg::REG_WIDTH-1:0]       value;
      logic                                typed;
      bgl_pkg::result_type                 outcome;
   } row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_button = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_led;
   logic [1:0]                          rsp_mode;
   logic [1:0]                          rsp_gesture;
   logic                                csr_we = 1'b0;
   logic [bgl_pkg::CSR_INDEX_WIDTH-1:0] csr_index = bgl_pkg::CSR_LONG_PRESS;
   logic [bgl_pkg::REG_WIDTH-1:0]       csr_wdata = '0;

   // Side band travelling with each request: a hand-written expectation, if any.
   logic                row_typed = 1'b0;
   bgl_pkg::result_type row_outcome = '0;

   // Mirror of the gesture engine and of its registers.
   logic [bgl_pkg::REG_WIDTH-1:0] long_press_cfg = bgl_pkg::RST_LONG_PRESS;
   logic [bgl_pkg::REG_WIDTH-1:0] gap_cfg = bgl_pkg::RST_GAP;
   logic [bgl_pkg::REG_WIDTH-1:0] window_cfg = bgl_pkg::RST_WINDOW;
   logic [bgl_pkg::REG_WIDTH-1:0] blink_half_cfg = bgl_pkg::RST_BLINK_HALF;
   bgl_pkg::phase_type            gesture_phase = bgl_pkg::PH_IDLE;
   logic [bgl_pkg::REG_WIDTH-1:0] phase_ticks = '0;
   logic [1:0]                    led_mode_now = bgl_pkg::MODE_NONE;
   logic                          led_on = 1'b0;
   logic [bgl_pkg::REG_WIDTH-1:0] blink_ticks = '0;

   bgl_pkg::result_type led_states_due[$];
   logic                button_plan[$];
   int unsigned         mismatches = 0;
   int unsigned         cycle_count = 0;
   int unsigned         req_gap_max = 10;
   int unsigned         rsp_stall_max = 10;
   int unsigned         rsp_stall_left = 0;

   row_type directed_rows [29] = '{
      // Straight after reset: nothing lit, a press only starts the check.
      '{ROW_BUTTON, '0, 24'd0, 1'b1, '{1'b0, bgl_pkg::MODE_NONE, bgl_pkg::GESTURE_NONE}},
      '{ROW_BUTTON, '0, 24'd1, 1'b1, '{1'b0, bgl_pkg::MODE_NONE, bgl_pkg::GESTURE_NONE}},
      '{ROW_BUTTON, '0, 24'd0, 1'b1, '{1'b0, bgl_pkg::MODE_NONE, bgl_pkg::GESTURE_NONE}},
      // Zero everywhere: every threshold behaves as one, the gap is skipped.
      '{ROW_CSR, bgl_pkg::CSR_LONG_PRESS, 24'd0, 1'b0, '0},
      '{ROW_CSR, bgl_pkg::CSR_GAP,        24'd0, 1'b0, '0},
      '{ROW_CSR, bgl_pkg::CSR_WINDOW,     24'd0, 1'b0, '0},
      '{ROW_CSR, bgl_pkg::CSR_BLINK_HALF, 24'd0, 1'b0, '0},
      '{ROW_BUTTON, '0, 24'd0, 1'b1, '{1'b0, bgl_pkg::MODE_NONE, bgl_pkg::GESTURE_NONE}},
      '{ROW_BUTTON, '0, 24'd1, 1'b1, '{1'b1, bgl_pkg::MODE_BLINK, bgl_pkg::GESTURE_DOUBLE}},
      '{ROW_BUTTON, '0, 24'd0, 1'b1, '{1'b0, bgl_pkg::MODE_BLINK, bgl_pkg::GESTURE_NONE}},
      '{ROW_BUTTON, '0, 24'd0, 1'b1, '{1'b1, bgl_pkg::MODE_BLINK, bgl_pkg::GESTURE_NONE}},
      // A press pauses blinking; holding it repeats the long press.
      '{ROW_BUTTON, '0, 24'd1, 1'b1, '{1'b1, bgl_pkg::MODE_BLINK, bgl_pkg::GESTURE_NONE}},
      '{ROW_BUTTON, '0, 24'd1, 1'b1, '{1'b1, bgl_pkg::MODE_STEADY, bgl_pkg::GESTURE_LONG}},
      '{ROW_BUTTON, '0, 24'd1, 1'b1, '{1'b1, bgl_pkg::MODE_STEADY, bgl_pkg::GESTURE_NONE}},
      '{ROW_BUTTON, '0, 24'd1, 1'b1, '{1'b1, bgl_pkg::MODE_STEADY, bgl_pkg::GESTURE_LONG}},
      '{ROW_BUTTON, '0, 24'd1, 1'b1, '{1'b1, bgl_pkg::MODE_STEADY, bgl_pkg::GESTURE_NONE}},
      // Short press whose window runs out leaves mode and LED alone.
      '{ROW_BUTTON, '0, 24'd0, 1'b1, '{1'b1, bgl_pkg::MODE_STEADY, bgl_pkg::GESTURE_NONE}},
      '{ROW_BUTTON, '0, 24'd0, 1'b1, '{1'b1, bgl_pkg::MODE_STEADY, bgl_pkg::GESTURE_NONE}},
      // A write to an unmapped index must change nothing.
      '{ROW_CSR, CSR_UNMAPPED,            24'hA5A5A5, 1'b0, '0},
      '{ROW_CSR, bgl_pkg::CSR_LONG_PRESS, REG_MAX, 1'b0, '0},
      '{ROW_CSR, bgl_pkg::CSR_GAP,        24'd2, 1'b0, '0},
      '{ROW_CSR, bgl_pkg::CSR_WINDOW,     24'd2, 1'b0, '0},
      '{ROW_CSR, bgl_pkg::CSR_BLINK_HALF, REG_MAX, 1'b0, '0},
      // Short press, release, two gap ticks, then a second press inside the window.
      '{ROW_BUTTON, '0, 24'd1, 1'b0, '0},
      '{ROW_BUTTON, '0, 24'd0, 1'b0, '0},
      '{ROW_BUTTON, '0, 24'd0, 1'b0, '0},
      '{ROW_BUTTON, '0, 24'd0, 1'b0, '0},
      '{ROW_BUTTON, '0, 24'd1, 1'b0, '0},
      '{ROW_BUTTON, '0, 24'd0, 1'b0, '0}
   };

   button_gesture_led_mode i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_button  (req_button),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_led     (rsp_led),
      .rsp_mode    (rsp_mode),
      .rsp_gesture (rsp_gesture),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // A threshold of zero counts as one.
   function automatic logic [bgl_pkg::REG_WIDTH-1:0] tick_limit(
      input logic [bgl_pkg::REG_WIDTH-1:0] reg_value);
      if (reg_value == '0) begin
         return bgl_pkg::REG_WIDTH'(1);
      end
      return reg_value;
   endfunction

   // Advances the mirrored engine by one button sample and returns the LED state it shows.
   function automatic bgl_pkg::result_type predict_led_state(input logic pressed);
      bgl_pkg::result_type outcome;
      outcome.gesture = bgl_pkg::GESTURE_NONE;
      case (gesture_phase)
         bgl_pkg::PH_IDLE: begin
            if (pressed) begin
               gesture_phase = bgl_pkg::PH_LONG;
               phase_ticks = '0;
            end else if (led_mode_now == bgl_pkg::MODE_BLINK) begin
               blink_ticks = blink_ticks + 1'b1;
               if (blink_ticks >= tick_limit(blink_half_cfg)) begin
                  led_on = ~led_on;
                  blink_ticks = '0;
               end
            end
         end
         bgl_pkg::PH_LONG: begin
            if (!pressed) begin
               phase_ticks = '0;
               gesture_phase = (gap_cfg == '0) ? bgl_pkg::PH_WINDOW : bgl_pkg::PH_GAP;
            end else begin
               phase_ticks = phase_ticks + 1'b1;
               if (phase_ticks >= tick_limit(long_press_cfg)) begin
                  outcome.gesture = bgl_pkg::GESTURE_LONG;
                  led_mode_now = bgl_pkg::MODE_STEADY;
                  led_on = 1'b1;
                  gesture_phase = bgl_pkg::PH_IDLE;
                  phase_ticks = '0;
               end
            end
         end
         bgl_pkg::PH_GAP: begin
            phase_ticks = phase_ticks + 1'b1;
            if (phase_ticks >= tick_limit(gap_cfg)) begin
               gesture_phase = bgl_pkg::PH_WINDOW;
               phase_ticks = '0;
            end
         end
         default: begin
            if (pressed) begin
               outcome.gesture = bgl_pkg::GESTURE_DOUBLE;
               led_mode_now = bgl_pkg::MODE_BLINK;
               led_on = ~led_on;
               blink_ticks = '0;
               gesture_phase = bgl_pkg::PH_IDLE;
               phase_ticks = '0;
            end else begin
               phase_ticks = phase_ticks + 1'b1;
               if (phase_ticks >= tick_limit(window_cfg)) begin
                  gesture_phase = bgl_pkg::PH_IDLE;
                  phase_ticks = '0;
               end
            end
         end
      endcase
      outcome.led = led_on;
      outcome.mode = led_mode_now;
      return outcome;
   endfunction

   // Keeps random gesture lengths short whatever the registers hold.
   function automatic int unsigned capped_span(input logic [bgl_pkg::REG_WIDTH-1:0] reg_value);
      if (reg_value == '0) begin
         return 1;
      end
      return (reg_value > SPAN_CAP) ? SPAN_CAP : int'(reg_value);
   endfunction

   // Mostly small values, now and then zero or all ones.
   function automatic logic [bgl_pkg::REG_WIDTH-1:0] draw_register_value();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick < 2) begin
         return '0;
      end else if (pick == 2) begin
         return REG_MAX;
      end
      return bgl_pkg::REG_WIDTH'($urandom_range(1, 12));
   endfunction

   task automatic push_level(input logic level, input int unsigned count);
      repeat (count) button_plan.push_back(level);
   endtask

   // Appends one gesture shaped around the current register values.
   task automatic plan_gesture();
      int unsigned hold_limit;
      int unsigned gap_len;
      int unsigned window_len;
      int unsigned kind;
      hold_limit = capped_span(long_press_cfg);
      gap_len = capped_span(gap_cfg);
      window_len = capped_span(window_cfg);
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         // Long press: sometimes a tick short, sometimes held on into a repeat.
         push_level(1'b1, hold_limit + $urandom_range(0, 3));
         push_level(1'b0, $urandom_range(1, 4));
      end else if (kind < 7) begin
         // Double click, second press landing in the gap, the window or just after it.
         push_level(1'b1, $urandom_range(1, hold_limit));
         push_level(1'b0, gap_len + $urandom_range(0, window_len + 1));
         push_level(1'b1, $urandom_range(1, 3));
         push_level(1'b0, $urandom_range(1, 5));
      end else if (kind < 9) begin
         push_level(1'b0, $urandom_range(1, 3 * capped_span(blink_half_cfg)));
      end else begin
         repeat ($urandom_range(1, 8)) button_plan.push_back($urandom_range(0, 1) != 0);
      end
   endtask

   // Presents one button sample after a random pause and waits for the transaction.
   task automatic send_button(input logic level, input logic typed,
                              input bgl_pkg::result_type outcome);
      int unsigned pause;
      pause = $urandom_range(0, req_gap_max);
      if (pause != 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_button <= level;
      row_typed <= typed;
      row_outcome <= outcome;
      do @(posedge clock); while (!req_ready);
   endtask

   // Waits until every result is in, then writes one register.
   task automatic write_register(input logic [bgl_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [bgl_pkg::REG_WIDTH-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (led_states_due.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         bgl_pkg::CSR_LONG_PRESS: long_press_cfg = value;
         bgl_pkg::CSR_GAP:        gap_cfg = value;
         bgl_pkg::CSR_WINDOW:     window_cfg = value;
         bgl_pkg::CSR_BLINK_HALF: blink_half_cfg = value;
         default: ;
      endcase
   endtask

   // Result side: compare each transaction with the oldest expectation, then record the
   // expectation of any request taken at the same edge, and draw the next stall.
   always @(posedge clock) begin : track_led_states
      bgl_pkg::result_type due;
      bgl_pkg::result_type predicted;
      int unsigned stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (led_states_due.size() == 0) begin
               $error("unexpected result: led %0d, mode %0d, gesture %0d",
                      rsp_led, rsp_mode, rsp_gesture);
               mismatches++;
            end else begin
               due = led_states_due.pop_front();
               if (rsp_led !== due.led) begin
                  $error("led: expected %0d, got %0d", due.led, rsp_led);
                  mismatches++;
               end
               if (rsp_mode !== due.mode) begin
                  $error("mode: expected %0d, got %0d", due.mode, rsp_mode);
                  mismatches++;
               end
               if (rsp_gesture !== due.gesture) begin
                  $error("gesture: expected %0d, got %0d", due.gesture, rsp_gesture);
                  mismatches++;
               end
            end
            stall = $urandom_range(0, rsp_stall_max);
            rsp_stall_left <= stall;
            rsp_ready <= (stall == 0);
         end else if (rsp_stall_left > 1) begin
            rsp_stall_left <= rsp_stall_left - 1;
         end else begin
            rsp_stall_left <= 0;
            rsp_ready <= 1'b1;
         end

         if (req_valid && req_ready) begin
            predicted = predict_led_state(req_button);
            led_states_due.push_back(row_typed ? row_outcome : predicted);
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** button_gesture_led_mode: FAILED **");
         $finish;
      end
   end

   // Stimulus: reset, the directed table, then random phases with fresh registers.
   initial begin
      int unsigned target;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_register(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_button(directed_rows[i].value[0], directed_rows[i].typed,
                        directed_rows[i].outcome);
         end
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         // The second phase holds every register at its ceiling.
         if (ph == 1) begin
            write_register(bgl_pkg::CSR_LONG_PRESS, REG_MAX);
            write_register(bgl_pkg::CSR_GAP, REG_MAX);
            write_register(bgl_pkg::CSR_WINDOW, REG_MAX);
            write_register(bgl_pkg::CSR_BLINK_HALF, REG_MAX);
            target = EXTREME_ITEMS;
         end else begin
            write_register(bgl_pkg::CSR_LONG_PRESS, draw_register_value());
            write_register(bgl_pkg::CSR_GAP, draw_register_value());
            write_register(bgl_pkg::CSR_WINDOW, draw_register_value());
            write_register(bgl_pkg::CSR_BLINK_HALF, draw_register_value());
            target = PHASE_ITEMS;
         end
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
         rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
         button_plan.delete();
         while (button_plan.size() < target) plan_gesture();
         foreach (button_plan[i]) send_button(button_plan[i], 1'b0, '0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (led_states_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("** button_gesture_led_mode: PASSED **");
      end else begin
         $display("** button_gesture_led_mode: FAILED **");
      end
      $finish;
   end

endmodule

>>> files.f
sv/bgl_pkg.sv
sv/bgl_cfg.sv
sv/bgl_fsm.sv
sv/button_gesture_led_mode.sv
test/button_gesture_led_mode_tb.sv
